// ===== rtl/ecal_pkg.sv =====
// ----------------------------------------------------------------------------
// ecal_pkg: shared types, constants and helpers for the epoch/BCD converter
// Holds the transaction payload types, the reciprocal constants used for the
// fixed divisions and the small calendar functions used by both datapaths.
// ----------------------------------------------------------------------------
package ecal_pkg;

  // Number of register stages in each datapath.
  localparam int STAGES = 5;

  typedef logic [STAGES-1:0] stg_en_t;

  // Request kinds carried in req_type.
  localparam logic REQ_ENCODE = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] epoch_in;
    logic [7:0]  sec_byte;
    logic [7:0]  min_byte;
    logic [7:0]  hour_byte;
    logic [7:0]  date_byte;
    logic [7:0]  month_byte;
    logic [7:0]  year_byte;
  } cvt_req_t;

  typedef struct packed {
    logic [31:0] epoch_out;
    logic [7:0]  sec_reg_out;
    logic [7:0]  min_reg_out;
    logic [7:0]  hour_reg_out;
    logic [7:0]  wkday_reg_out;
    logic [7:0]  date_reg_out;
    logic [7:0]  month_reg_out;
    logic [7:0]  year_reg_out;
  } cvt_rsp_t;

  // Register image produced by the encode path.
  typedef struct packed {
    logic [7:0] sec_reg;
    logic [7:0] min_reg;
    logic [7:0] hour_reg;
    logic [7:0] date_reg;
    logic [7:0] month_reg;
    logic [7:0] year_reg;
  } reg_img_t;

  // Calendar constants.
  localparam logic [19:0] DAYS_TO_EPOCH  = 20'd719468;
  localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
  localparam logic [11:0] DECODE_CENTURY = 12'd2000;
  localparam logic [7:0]  WKDAY_REG      = 8'h09;
  localparam logic [7:0]  OSC_START      = 8'h80;

  // Days from epoch seconds: seconds >> 7, then divide by 675 with a reciprocal.
  // Exact for every 25-bit dividend.
  localparam int          DAY_DIVISOR = 675;
  localparam int          DAY_SHIFT   = 35;
  localparam logic [25:0] DAY_RECIP   =
    26'(((64'd1 << DAY_SHIFT) + 64'(DAY_DIVISOR) - 64'd1) / 64'(DAY_DIVISOR));

  // Year estimate (10000*g + 14780) / 3652425 rebased to 1969, where g is the
  // day count since 1970 plus DAYS_TO_EPOCH. The numerator stays below 2^29.
  localparam logic [11:0] YEAR_BASE      = 12'd1969;
  localparam logic [28:0] YEAR_BIAS      = 29'd3069955;
  localparam logic [13:0] YEAR_NUM_SCALE = 14'd10000;
  localparam int          YEAR_DIVISOR   = 3652425;
  localparam int          YEAR_SHIFT     = 51;
  localparam logic [29:0] YEAR_RECIP     =
    30'(((64'd1 << YEAR_SHIFT) + 64'(YEAR_DIVISOR) - 64'd1) / 64'(YEAR_DIVISOR));

  // Hours from seconds of the day, minutes from seconds of the hour.
  localparam int          HOUR_SHIFT = 29;
  localparam logic [17:0] HOUR_RECIP =
    18'(((64'd1 << HOUR_SHIFT) + 64'(SECS_PER_HOUR) - 64'd1) / 64'(SECS_PER_HOUR));
  localparam int          MIN_SHIFT  = 18;
  localparam logic [12:0] MIN_RECIP  =
    13'(((64'd1 << MIN_SHIFT) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));

  // Value of a tens/units nibble pair, nibbles taken at face value.
  function automatic logic [7:0] bcd_value(input logic [3:0] tens, input logic [3:0] units);
    return 8'(tens) * 8'd10 + 8'(units);
  endfunction

  // Binary to two BCD digits for values below 100.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = 15'(v) * 15'd205;
    tens  = prod[14:11];
    units = v - 7'(tens) * 7'd10;
    return {tens, units[3:0]};
  endfunction

  // First day of each month in a year that starts in March.
  function automatic logic [8:0] month_start(input logic [3:0] mo);
    logic [8:0] d;
    case (mo)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Days before a year; the century terms are resolved by compares, which is
  // exact for years 1900 to 2199.
  function automatic logic [19:0] days_before_year(input logic [11:0] y);
    logic [19:0] cent;
    logic [19:0] quad;
    cent = 20'd19 + 20'(y >= 12'd2000) + 20'(y >= 12'd2100);
    quad = 20'd4 + 20'(y >= 12'd2000);
    return 20'(y) * 20'd365 + 20'(y[11:2]) - cent + quad;
  endfunction

endpackage

// ===== rtl/ecal_if.sv =====
// ----------------------------------------------------------------------------
// ecal_if: valid/ready channels of the epoch/BCD converter
// Request and response channels, each with a source and a sink modport.
// ----------------------------------------------------------------------------
interface ecal_req_if import ecal_pkg::*; ();
  logic     valid;
  logic     ready;
  cvt_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ecal_rsp_if import ecal_pkg::*; ();
  logic     valid;
  logic     ready;
  cvt_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ecal_decode.sv =====
// ----------------------------------------------------------------------------
// ecal_decode: register image to epoch seconds
// Five register stages: field decode, day count, day multiply, sum, align.
// ----------------------------------------------------------------------------
module ecal_decode import ecal_pkg::*; (
  input  logic        clk,
  input  stg_en_t     en,
  input  cvt_req_t    req,
  output logic [31:0] epoch
);

  logic [6:0]  sec1_r, sec1_nxt, min1_r, min1_nxt;
  logic [5:0]  hr1_r, hr1_nxt, day1_r, day1_nxt;
  logic [3:0]  mofs1_r, mofs1_nxt;
  logic [11:0] year1_r, year1_nxt;
  logic        zero1_r, zero1_nxt;
  logic [4:0]  mon_v;
  logic [5:0]  mshift;
  logic [11:0] yr_v;

  logic [16:0] days2_r, days2_nxt;
  logic [17:0] hms2_r, hms2_nxt;
  logic        zero2_r;
  logic [19:0] days_sum;

  logic [31:0] prod3_r, prod3_nxt;
  logic [17:0] hms3_r;
  logic        zero3_r;
  logic [33:0] day_prod;

  logic [31:0] ep4_r, ep4_nxt;
  logic [31:0] ep5_r;

  // Stage 1: take the BCD fields apart and shift the year to start in March.
  always_comb begin
    sec1_nxt = 7'(bcd_value({1'b0, req.sec_byte[6:4]}, req.sec_byte[3:0]));
    min1_nxt = 7'(bcd_value({1'b0, req.min_byte[6:4]}, req.min_byte[3:0]));
    hr1_nxt  = 6'(bcd_value({2'b0, req.hour_byte[5:4]}, req.hour_byte[3:0]));
    day1_nxt = 6'(bcd_value({2'b0, req.date_byte[5:4]}, req.date_byte[3:0]));
    mon_v    = 5'(bcd_value({3'b0, req.month_byte[4]}, req.month_byte[3:0]));
    yr_v     = 12'(bcd_value(req.year_byte[7:4], req.year_byte[3:0])) + DECODE_CENTURY;
    mshift   = 6'(mon_v) + 6'd9;
    if (mshift >= 6'd24) begin
      mofs1_nxt = 4'(mshift - 6'd24);
    end else if (mshift >= 6'd12) begin
      mofs1_nxt = 4'(mshift - 6'd12);
    end else begin
      mofs1_nxt = 4'(mshift);
    end
    year1_nxt = yr_v - 12'(mofs1_nxt >= 4'd10);
    zero1_nxt = (mon_v == 5'd0) || (day1_nxt == 6'd0);
  end

  // Stage 2: days since the epoch and seconds within the day.
  always_comb begin
    days_sum  = days_before_year(year1_r) + 20'(month_start(mofs1_r)) + 20'(day1_r)
                - 20'd1 - DAYS_TO_EPOCH;
    days2_nxt = days_sum[16:0];
    hms2_nxt  = 18'(hr1_r) * 18'(SECS_PER_HOUR) + 18'(min1_r) * 18'(SECS_PER_MIN)
                + 18'(sec1_r);
  end

  // Stage 3: days to seconds, kept modulo 2^32.
  always_comb begin
    day_prod  = 34'(days2_r) * 34'(SECS_PER_DAY);
    prod3_nxt = day_prod[31:0];
  end

  // Stage 4: final sum, forced to zero for a zero month or day.
  always_comb begin
    ep4_nxt = zero3_r ? 32'd0 : prod3_r + 32'(hms3_r);
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      sec1_r  <= sec1_nxt;
      min1_r  <= min1_nxt;
      hr1_r   <= hr1_nxt;
      day1_r  <= day1_nxt;
      mofs1_r <= mofs1_nxt;
      year1_r <= year1_nxt;
      zero1_r <= zero1_nxt;
    end
    if (en[1]) begin
      days2_r <= days2_nxt;
      hms2_r  <= hms2_nxt;
      zero2_r <= zero1_r;
    end
    if (en[2]) begin
      prod3_r <= prod3_nxt;
      hms3_r  <= hms2_r;
      zero3_r <= zero2_r;
    end
    if (en[3]) begin
      ep4_r <= ep4_nxt;
    end
    if (en[4]) begin
      ep5_r <= ep4_r;
    end
  end

  assign epoch = ep5_r;

endmodule

// ===== rtl/ecal_encode.sv =====
// ----------------------------------------------------------------------------
// ecal_encode: epoch seconds to register image
// Five register stages: day split, remainder and year numerator, year and
// hour estimates, year correction, month and minute split. BCD packing
// follows the last stage.
// ----------------------------------------------------------------------------
module ecal_encode import ecal_pkg::*; (
  input  logic        clk,
  input  stg_en_t     en,
  input  logic [31:0] epoch_in,
  output reg_img_t    img
);

  logic [50:0] day_prod;
  logic [15:0] days1_r, days1_nxt;
  logic [16:0] tlo1_r;

  logic [16:0] daysec_lo;
  logic [16:0] rem2_r, rem2_nxt;
  logic [28:0] num2_r, num2_nxt;
  logic [15:0] days2_r;

  logic [58:0] yr_prod;
  logic [34:0] hr_prod;
  logic [7:0]  yofs3_r, yofs3_nxt;
  logic [4:0]  hour3_r, hour3_nxt;
  logic [16:0] rem3_r;
  logic [15:0] days3_r;

  logic [11:0] year_est;
  logic [19:0] g2;
  logic [20:0] d0, d1;
  logic [16:0] hr_secs;
  logic [8:0]  ddd4_r, ddd4_nxt;
  logic [11:0] year4_r, year4_nxt;
  logic [11:0] r2_4_r, r2_4_nxt;
  logic [4:0]  hour4_r;

  logic [3:0]  mi;
  logic [8:0]  day_full;
  logic [11:0] yfull, cent;
  logic [24:0] min_prod;
  logic [3:0]  month5_r, month5_nxt;
  logic [4:0]  day5_r, day5_nxt;
  logic [6:0]  yy5_r, yy5_nxt;
  logic [4:0]  hour5_r;
  logic [5:0]  minute5_r, minute5_nxt;
  logic [11:0] r2_5_r;

  logic [11:0] secs;

  // Stage 1: whole days via a reciprocal of 675 on the seconds shifted by 7.
  always_comb begin
    day_prod  = 51'(epoch_in[31:7]) * 51'(DAY_RECIP);
    days1_nxt = day_prod[DAY_SHIFT +: 16];
  end

  // Stage 2: seconds of the day and the numerator of the year estimate.
  always_comb begin
    daysec_lo = 17'(days1_r) * SECS_PER_DAY;
    rem2_nxt  = tlo1_r - daysec_lo;
    num2_nxt  = 29'(days1_r) * 29'(YEAR_NUM_SCALE) + YEAR_BIAS;
  end

  // Stage 3: year offset and hour, both by reciprocal multiplication.
  always_comb begin
    yr_prod   = 59'(num2_r) * 59'(YEAR_RECIP);
    yofs3_nxt = yr_prod[YEAR_SHIFT +: 8];
    hr_prod   = 35'(rem2_r) * 35'(HOUR_RECIP);
    hour3_nxt = hr_prod[HOUR_SHIFT +: 5];
  end

  // Stage 4: step the year back when the estimate overshoots, and take the whole hours off the seconds of the day.
  always_comb begin
    year_est = YEAR_BASE + 12'(yofs3_r);
    g2       = 20'(days3_r) + DAYS_TO_EPOCH;
    d0       = 21'(g2) - 21'(days_before_year(year_est));
    d1       = 21'(g2) - 21'(days_before_year(year_est - 12'd1));
    if (d0[20]) begin
      ddd4_nxt  = d1[8:0];
      year4_nxt = year_est - 12'd1;
    end else begin
      ddd4_nxt  = d0[8:0];
      year4_nxt = year_est;
    end
    hr_secs  = 17'(hour3_r) * 17'(SECS_PER_HOUR);
    r2_4_nxt = 12'(rem3_r - hr_secs);
  end

  // Stage 5: month index from the month start table, then day, year, minute.
  always_comb begin
    mi = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (ddd4_r >= month_start(4'(k))) begin
        mi = 4'(k);
      end
    end
    month5_nxt = (mi < 4'd10) ? mi + 4'd3 : mi - 4'd9;
    day_full   = ddd4_r - month_start(mi) + 9'd1;
    day5_nxt   = day_full[4:0];
    yfull      = year4_r + 12'(mi >= 4'd10);
    if (yfull >= 12'd2100) begin
      cent = 12'd2100;
    end else if (yfull >= 12'd2000) begin
      cent = 12'd2000;
    end else begin
      cent = 12'd1900;
    end
    yy5_nxt     = 7'(yfull - cent);
    min_prod    = 25'(r2_4_r) * 25'(MIN_RECIP);
    minute5_nxt = min_prod[MIN_SHIFT +: 6];
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      days1_r <= days1_nxt;
      tlo1_r  <= epoch_in[16:0];
    end
    if (en[1]) begin
      rem2_r  <= rem2_nxt;
      num2_r  <= num2_nxt;
      days2_r <= days1_r;
    end
    if (en[2]) begin
      yofs3_r <= yofs3_nxt;
      hour3_r <= hour3_nxt;
      rem3_r  <= rem2_r;
      days3_r <= days2_r;
    end
    if (en[3]) begin
      ddd4_r  <= ddd4_nxt;
      year4_r <= year4_nxt;
      r2_4_r  <= r2_4_nxt;
      hour4_r <= hour3_r;
    end
    if (en[4]) begin
      month5_r  <= month5_nxt;
      day5_r    <= day5_nxt;
      yy5_r     <= yy5_nxt;
      hour5_r   <= hour4_r;
      minute5_r <= minute5_nxt;
      r2_5_r    <= r2_4_r;
    end
  end

  // BCD packing of the last stage.
  always_comb begin
    secs          = r2_5_r - 12'(minute5_r) * 12'(SECS_PER_MIN);
    img.sec_reg   = to_bcd(7'(secs[5:0])) | OSC_START;
    img.min_reg   = to_bcd(7'(minute5_r));
    img.hour_reg  = to_bcd(7'(hour5_r));
    img.date_reg  = to_bcd(7'(day5_r));
    img.month_reg = to_bcd(7'(month5_r));
    img.year_reg  = to_bcd(yy5_r);
  end

endmodule

// ===== rtl/epoch_bcd_calendar_converter.sv =====
// ----------------------------------------------------------------------------
// epoch_bcd_calendar_converter: Unix epoch seconds <-> RTC BCD register image
// Top level: stage valid bits, backpressure and the output register around
// the decode and encode datapaths.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Handshake    | Transaction
//  in_req   | in  | valid/ready  | req_type, epoch_in, six BCD register bytes
//  out_rsp  | out | valid/ready  | epoch_out and seven register bytes
//
//  One transaction per cycle is accepted while no stall holds the input; a
//  result passes the five datapath stages and then the output register
//  before it appears at out_rsp. Reset clears only the stage valid bits and
//  the output valid. A stall holds each full stage; empty stages ahead of it
//  keep filling, so the input is still taken while a finished result waits
//  at the output, as long as some stage is empty.
// ----------------------------------------------------------------------------
module epoch_bcd_calendar_converter import ecal_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  ecal_req_if.sink     in_req,
  ecal_rsp_if.source   out_rsp
);

  stg_en_t             en;
  logic                out_en;
  logic [STAGES-1:0]   vld_r, vld_nxt;
  logic [STAGES-1:0]   kind_r, kind_nxt;
  logic                out_valid_r, out_valid_nxt;
  cvt_rsp_t            out_data_r, out_data_nxt;
  cvt_rsp_t            rsp_sel;
  logic [31:0]         dec_epoch;
  reg_img_t            enc_img;

  ecal_decode u_decode (
    .clk   (clk),
    .en    (en),
    .req   (in_req.data),
    .epoch (dec_epoch)
  );

  ecal_encode u_encode (
    .clk      (clk),
    .en       (en),
    .epoch_in (in_req.data.epoch_in),
    .img      (enc_img)
  );

  // Stage enables: a stage loads when it is empty or its successor moves.
  always_comb begin
    out_en         = !out_valid_r || out_rsp.ready;
    en[STAGES-1]   = !vld_r[STAGES-1] || out_en;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  // Valid bits and request kind travel with the data.
  always_comb begin
    vld_nxt[0]  = en[0] ? in_req.valid : vld_r[0];
    kind_nxt[0] = en[0] ? in_req.data.req_type : kind_r[0];
    for (int k = 1; k < STAGES; k++) begin
      vld_nxt[k]  = en[k] ? vld_r[k-1] : vld_r[k];
      kind_nxt[k] = en[k] ? kind_r[k-1] : kind_r[k];
    end
  end

  // Result selection by request kind.
  always_comb begin
    case (kind_r[STAGES-1])
      REQ_ENCODE: begin
        rsp_sel.epoch_out     = 32'd0;
        rsp_sel.sec_reg_out   = enc_img.sec_reg;
        rsp_sel.min_reg_out   = enc_img.min_reg;
        rsp_sel.hour_reg_out  = enc_img.hour_reg;
        rsp_sel.wkday_reg_out = WKDAY_REG;
        rsp_sel.date_reg_out  = enc_img.date_reg;
        rsp_sel.month_reg_out = enc_img.month_reg;
        rsp_sel.year_reg_out  = enc_img.year_reg;
      end
      default: begin
        rsp_sel           = '0;
        rsp_sel.epoch_out = dec_epoch;
      end
    endcase
    out_valid_nxt = out_en ? vld_r[STAGES-1] : out_valid_r;
    out_data_nxt  = out_en ? rsp_sel : out_data_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_req.ready  = en[0];
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_data_r;

  // A full last stage behind a stalled output must keep its transaction.
  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[STAGES-1] && out_valid_r && !out_rsp.ready) |=> vld_r[STAGES-1])
    else $error("last stage dropped a transaction during a stall");

  // With the output register empty the whole pipeline can move.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_req.ready)
    else $error("input stalled while the output register is empty");

  // An accepted transaction occupies the first stage on the next cycle.
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> vld_r[0])
    else $error("accepted transaction not captured in the first stage");

  // Every result has either the encode shape or the decode shape.
  a_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_rsp.data.epoch_out == 32'd0 &&
                      out_rsp.data.wkday_reg_out == WKDAY_REG &&
                      out_rsp.data.sec_reg_out[7]) ||
                     (out_rsp.data.wkday_reg_out == 8'd0 &&
                      out_rsp.data.sec_reg_out == 8'd0)))
    else $error("result mixes encode and decode fields");

endmodule
